FILE: rtl/ogru_pkg.sv
// Shared types and constants for the occupancy grid ray update block.
// No dependencies; imported by every module of the block but ogru_fifo.
package ogru_pkg;

    localparam int unsigned CRD_W = 12;  // signed coordinate fields
    localparam int unsigned CW    = 9;   // on-map coordinate / size width
    localparam int unsigned EW    = 12;  // Bresenham error term
    localparam int unsigned DW_16 = 16;  // log-odds config and result width

    localparam logic OP_RAY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_START_OFF = 2'd1;
    localparam logic [1:0] ST_END_OFF   = 2'd2;

    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FREE_DELTA  = 3'd2;
    localparam logic [2:0] REG_OCC_DELTA   = 3'd3;
    localparam logic [2:0] REG_PRIOR       = 3'd4;

    // Classified item as queued between front and back.
    typedef struct packed {
        logic                 op;
        logic [1:0]           status;
        logic [CW-1:0]        touched;
        logic [CW-1:0]        major;
        logic signed [EW-1:0] err0;
        logic signed [EW-1:0] e_inc;   // err step when no minor move
        logic signed [EW-1:0] e_dec;   // err step after a minor move
    } t_job;

endpackage

FILE: rtl/occupancy_grid_ray_update.sv
// Log-odds occupancy grid with Bresenham ray updates; uses ogru_pkg, front, queue, back.
// Read item: front register, queue pop with the cell read, then result register. Ray item:
// front register, queue pop, one read-modify-write per line cell (major+1 cells), result.
// The front takes new words while the back works on one item, until the queue is full.
// Reset (synchronous, active low) clears control state, then a clearing pass writes
// GRID_SIDE*GRID_SIDE cells with s_axis_tready low.
module occupancy_grid_ray_update #(
    parameter int unsigned GRID_SIDE = 256,
    parameter int unsigned CELL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // status, cell_value, cells_touched, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ogru_pkg::*;

    localparam int unsigned AW     = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int unsigned WCLAMP = (GRID_SIDE > 511) ? 511 : GRID_SIDE;
    localparam int unsigned QW     = $bits(t_job) + 3 * AW;

    logic [CW-1:0]    r_gw, r_gh;
    logic [DW_16-1:0] r_fd, r_od, r_pr;
    logic [2:0]       reg_idx;
    logic             cfg_wr;
    logic [CW-1:0]    w_eff, h_eff;

    t_job             f_job, b_job;
    logic [AW-1:0]    f_addr, f_inc_a, f_inc_b;
    logic [AW-1:0]    b_addr, b_inc_a, b_inc_b;
    logic             push, pop, q_full, q_valid, clr;
    logic [QW-1:0]    q_din, q_dout;
    logic [1:0]       o_st;
    logic [DW_16-1:0] o_val;
    logic [CW-1:0]    o_tch;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= CW'(256);
            r_gh <= CW'(256);
            r_fd <= 16'hFF9A;   // -102
            r_od <= 16'h00D9;   // 217
            r_pr <= 16'h0000;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  r_gw <= pwdata[CW-1:0];
                REG_GRID_HEIGHT: r_gh <= pwdata[CW-1:0];
                REG_FREE_DELTA:  r_fd <= pwdata[DW_16-1:0];
                REG_OCC_DELTA:   r_od <= pwdata[DW_16-1:0];
                REG_PRIOR:       r_pr <= pwdata[DW_16-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = {{(32-CW){1'b0}}, r_gw};
            REG_GRID_HEIGHT: prdata = {{(32-CW){1'b0}}, r_gh};
            REG_FREE_DELTA:  prdata = {16'h0000, r_fd};
            REG_OCC_DELTA:   prdata = {16'h0000, r_od};
            REG_PRIOR:       prdata = {16'h0000, r_pr};
            default:         prdata = '0;
        endcase
    end

    assign w_eff = (r_gw > CW'(WCLAMP)) ? CW'(WCLAMP) : r_gw;
    assign h_eff = (r_gh > CW'(WCLAMP)) ? CW'(WCLAMP) : r_gh;

    ogru_front #(.AW(AW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (s_axis_tuser),
        .i_sx     (s_axis_tdata[11:0]),
        .i_sy     (s_axis_tdata[23:12]),
        .i_ex     (s_axis_tdata[35:24]),
        .i_ey     (s_axis_tdata[47:36]),
        .i_w      (w_eff),
        .i_h      (h_eff),
        .i_clr    (clr),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (f_job),
        .o_addr   (f_addr),
        .o_inc_a  (f_inc_a),
        .o_inc_b  (f_inc_b)
    );

    assign q_din = {f_job, f_addr, f_inc_a, f_inc_b};
    assign {b_job, b_addr, b_inc_a, b_inc_b} = q_dout;

    ogru_fifo #(.DW(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_dout)
    );

    ogru_back #(
        .GRID_SIDE (GRID_SIDE),
        .CELL_BITS (CELL_BITS),
        .AW        (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (pop),
        .i_job        (b_job),
        .i_addr       (b_addr),
        .i_inc_a      (b_inc_a),
        .i_inc_b      (b_inc_b),
        .i_free_delta (r_fd),
        .i_occ_delta  (r_od),
        .i_prior      (r_pr),
        .o_clr        (clr),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (o_st),
        .o_value      (o_val),
        .o_touched    (o_tch)
    );

    assign m_axis_tdata = {5'b0, o_tch, o_val, o_st};

endmodule

FILE: rtl/ogru_fifo.sv
// Two-entry queue between the front (classify) and back (grid walk) parts.
// Generic data width; no package dependency.
module ogru_fifo #(
    parameter int unsigned DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: rtl/ogru_front.sv
// Front part: takes input words, checks map bounds, sets up the Bresenham walk.
// Depends on ogru_pkg.
module ogru_front #(
    parameter int unsigned AW = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [ogru_pkg::CRD_W-1:0]    i_sx,
    input  logic [ogru_pkg::CRD_W-1:0]    i_sy,
    input  logic [ogru_pkg::CRD_W-1:0]    i_ex,
    input  logic [ogru_pkg::CRD_W-1:0]    i_ey,
    input  logic [ogru_pkg::CW-1:0]       i_w,
    input  logic [ogru_pkg::CW-1:0]       i_h,
    input  logic                          i_clr,
    input  logic                          i_q_full,
    output logic                          o_push,
    output ogru_pkg::t_job                o_job,
    output logic [AW-1:0]                 o_addr,
    output logic [AW-1:0]                 o_inc_a,
    output logic [AW-1:0]                 o_inc_b
);
    import ogru_pkg::*;

    logic             r_iv;
    logic             r_op;
    logic [CRD_W-1:0] r_sx, r_sy, r_ex, r_ey;

    logic             acc;
    logic             s_on, e_on;
    logic [CW-1:0]    sxn, syn, exn, eyn;
    logic signed [CW:0] dx, dy;
    logic [CW:0]      adx, ady;
    logic [CW-1:0]    ax, ay, major, minor;
    logic             xpos, ypos, x_major;
    logic [AW-1:0]    xinc, winc, maj_inc, min_inc;
    logic [CW-1:0]    mx, my;
    logic [2*CW-1:0]  prod;
    logic [2*CW:0]    lin;
    logic signed [EW-1:0] two_min, two_maj;

    function automatic logic on_map(input logic [CRD_W-1:0] c, input logic [CW-1:0] lim);
        on_map = !c[CRD_W-1] && (c[CRD_W-2:0] < {{(CRD_W-1-CW){1'b0}}, lim});
    endfunction

    assign o_push  = r_iv && !i_q_full;
    assign o_ready = !i_clr && (!r_iv || !i_q_full);
    assign acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (acc) begin
            r_iv <= 1'b1;
        end else if (o_push) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op <= i_op;
            r_sx <= i_sx;
            r_sy <= i_sy;
            r_ex <= i_ex;
            r_ey <= i_ey;
        end
    end

    always_comb begin
        s_on = on_map(r_sx, i_w) && on_map(r_sy, i_h);
        e_on = on_map(r_ex, i_w) && on_map(r_ey, i_h);
        sxn  = r_sx[CW-1:0];
        syn  = r_sy[CW-1:0];
        exn  = r_ex[CW-1:0];
        eyn  = r_ey[CW-1:0];

        dx   = $signed({1'b0, exn}) - $signed({1'b0, sxn});
        dy   = $signed({1'b0, eyn}) - $signed({1'b0, syn});
        adx  = dx[CW] ? -dx : dx;
        ady  = dy[CW] ? -dy : dy;
        ax   = adx[CW-1:0];
        ay   = ady[CW-1:0];
        xpos = !dx[CW] && (dx != '0);
        ypos = !dy[CW] && (dy != '0);
        x_major = (ax > ay);
        major   = x_major ? ax : ay;
        minor   = x_major ? ay : ax;

        // x step moves one cell, y step moves one row
        xinc    = xpos ? AW'(1) : '1;
        winc    = ypos ? AW'(i_w) : AW'(0) - AW'(i_w);
        maj_inc = x_major ? xinc : winc;
        min_inc = x_major ? winc : xinc;

        two_min = $signed({{(EW-CW-1){1'b0}}, minor, 1'b0});
        two_maj = $signed({{(EW-CW-1){1'b0}}, major, 1'b0});

        mx   = (r_op == OP_READ) ? exn : sxn;
        my   = (r_op == OP_READ) ? eyn : syn;
        prod = my * i_w;
        lin  = {1'b0, prod} + {{(CW+1){1'b0}}, mx};

        o_job.op      = r_op;
        if (r_op == OP_READ) begin
            o_job.status = e_on ? ST_OK : ST_END_OFF;
        end else begin
            priority if (!s_on) o_job.status = ST_START_OFF;
            else if (!e_on)     o_job.status = ST_END_OFF;
            else                o_job.status = ST_OK;
        end
        o_job.touched = major + CW'(1);
        o_job.major   = major;
        o_job.err0    = two_min - $signed({{(EW-CW){1'b0}}, major});
        o_job.e_inc   = two_min;
        o_job.e_dec   = two_min - two_maj;
        o_addr  = AW'(lin);
        o_inc_a = maj_inc;
        o_inc_b = maj_inc + min_inc;
    end

endmodule

FILE: rtl/ogru_back.sv
// Back part: grid memory, clearing pass, per-cell read-modify-write walk,
// cell reads and the result register. Depends on ogru_pkg.
module ogru_back #(
    parameter int unsigned GRID_SIDE = 256,
    parameter int unsigned CELL_BITS = 16,
    parameter int unsigned AW        = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  ogru_pkg::t_job              i_job,
    input  logic [AW-1:0]               i_addr,
    input  logic [AW-1:0]               i_inc_a,
    input  logic [AW-1:0]               i_inc_b,
    input  logic [ogru_pkg::DW_16-1:0]  i_free_delta,
    input  logic [ogru_pkg::DW_16-1:0]  i_occ_delta,
    input  logic [ogru_pkg::DW_16-1:0]  i_prior,
    output logic                        o_clr,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [ogru_pkg::DW_16-1:0]  o_value,
    output logic [ogru_pkg::CW-1:0]     o_touched
);
    import ogru_pkg::*;

    localparam int unsigned DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int unsigned SW    = ((CELL_BITS > DW_16) ? CELL_BITS : DW_16) + 1;
    localparam logic signed [SW-1:0] CMAX = {{(SW-CELL_BITS+1){1'b0}}, {(CELL_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] CMIN = ~CMAX;
    localparam logic signed [SW-1:0] VMAX = {{(SW-DW_16+1){1'b0}}, {(DW_16-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;

    logic [CELL_BITS-1:0] r_mem [DEPTH];
    logic [CELL_BITS-1:0] r_rdata;

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_clr;
    logic [AW-1:0]        r_addr, r_inc_a, r_inc_b;
    logic signed [EW-1:0] r_err, r_e_inc, r_e_dec;
    logic [CW-1:0]        r_cnt, r_touched;
    logic                 r_wv, r_wlast;
    logic [AW-1:0]        r_wa;
    logic                 r_ov;
    logic [1:0]           r_ost;
    logic [DW_16-1:0]     r_oval;
    logic [CW-1:0]        r_otch;

    logic                 out_free, out_load;
    logic [1:0]           out_st;
    logic [DW_16-1:0]     out_val;
    logic [CW-1:0]        out_tch;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa, mem_ra;
    logic [CELL_BITS-1:0] mem_wd;
    logic signed [SW-1:0] c_ext, d_ext, p_ext, wsum, rsum;
    logic [DW_16-1:0]     delta;
    logic [DW_16-1:0]     rd_val;

    assign o_clr     = (r_state == S_CLEAR);
    assign out_free  = !r_ov || i_ready;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid && out_free;
    assign o_valid   = r_ov;
    assign o_status  = r_ost;
    assign o_value   = r_oval;
    assign o_touched = r_otch;

    // cell update and read saturation
    always_comb begin
        delta = r_wlast ? i_occ_delta : i_free_delta;
        c_ext = $signed({{(SW-CELL_BITS){r_rdata[CELL_BITS-1]}}, r_rdata});
        d_ext = $signed({{(SW-DW_16){delta[DW_16-1]}}, delta});
        p_ext = $signed({{(SW-DW_16){i_prior[DW_16-1]}}, i_prior});
        wsum  = c_ext + d_ext;
        rsum  = c_ext + p_ext;
        priority if (wsum > CMAX) mem_wd = CMAX[CELL_BITS-1:0];
        else if (wsum < CMIN)     mem_wd = CMIN[CELL_BITS-1:0];
        else                      mem_wd = wsum[CELL_BITS-1:0];
        priority if (rsum > VMAX) rd_val = VMAX[DW_16-1:0];
        else if (rsum < VMIN)     rd_val = VMIN[DW_16-1:0];
        else                      rd_val = rsum[DW_16-1:0];
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
        end else begin
            mem_we = r_wv;
            mem_wa = r_wa;
        end
        mem_ra = (r_state == S_IDLE) ? i_addr : r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= (r_state == S_CLEAR) ? '0 : mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        out_st   = ST_OK;
        out_val  = '0;
        out_tch  = '0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_q_pop) begin
                    if (i_job.status != ST_OK) begin
                        out_load = 1'b1;
                        out_st   = i_job.status;
                    end else if (i_job.op == OP_READ) begin
                        n_state = S_RDATA;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_cnt == '0) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                out_load = 1'b1;
                out_tch  = r_touched;
                n_state  = S_IDLE;
            end
            S_RDATA: begin
                out_load = 1'b1;
                out_val  = rd_val;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_wv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            r_wv <= (r_state == S_WALK);
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ost  <= out_st;
            r_oval <= out_val;
            r_otch <= out_tch;
        end
        if (o_q_pop) begin
            r_addr    <= i_addr;
            r_inc_a   <= i_inc_a;
            r_inc_b   <= i_inc_b;
            r_err     <= i_job.err0;
            r_e_inc   <= i_job.e_inc;
            r_e_dec   <= i_job.e_dec;
            r_cnt     <= i_job.major;
            r_touched <= i_job.touched;
        end else if (r_state == S_WALK) begin
            // non-negative error means a minor-axis step after this cell
            r_addr <= r_addr + (r_err[EW-1] ? r_inc_a : r_inc_b);
            r_err  <= r_err + (r_err[EW-1] ? r_e_inc : r_e_dec);
            r_cnt  <= r_cnt - CW'(1);
        end
        r_wa    <= r_addr;
        r_wlast <= (r_cnt == '0);
    end

    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (r_state == S_WALK || r_state == S_FLUSH))
        else $error("cell write outside a ray walk");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_cnt == '0) |=> (r_state == S_FLUSH && r_wv && r_wlast))
        else $error("last cell of a ray not written with end flag");

    a_flush_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_state == S_IDLE && r_ov))
        else $error("ray finished without a result");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_q_pop)
        else $error("queue popped during clearing pass");

endmodule

FILE: dv/grid_ray_checker.sv
// Checker for occupancy_grid_ray_update: follows register writes, predicts every result word
// from its own copy of the log-odds grid and compares results in order.
// Depends on ogru_pkg; instantiated by tb_top beside the block.
module grid_ray_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    input  logic        s_axis_tuser,   // opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // status, cell_value, cells_touched, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_pending,
    output int          o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import ogru_pkg::*;

    // Result word, lowest bits last.
    typedef struct packed {
        logic [4:0]  pad;
        logic [8:0]  touched;
        logic [15:0] value;
        logic [1:0]  status;
    } t_answer;

    logic signed [15:0] cells [0:65535];
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic signed [15:0] free_d;
    logic signed [15:0] occ_d;
    logic signed [15:0] prior_d;

    t_answer answers_due[$];
    t_answer got;
    t_answer want;
    int      pushed;
    int      popped;
    int      bad;

    function automatic int span(logic [8:0] r);
        return (r > 9'd256) ? 256 : int'(r);
    endfunction

    function automatic bit on_grid(int x, int y);
        return x >= 0 && y >= 0 && x < span(width_reg) && y < span(height_reg);
    endfunction

    function automatic int flat(int x, int y);
        return (y * span(width_reg) + x) % 65536;
    endfunction

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Works out the result of one word and applies a ray to the grid copy.
    function automatic t_answer apply_to_grid(logic op, logic [47:0] d);
        int      sx, sy, ex, ey, dx, dy, xs, ys, ax, ay;
        int      mxx, mxy, myx, myy, major, minor, err, stp, i, cx, cy, k;
        t_answer a;
        sx = signed'(d[11:0]);
        sy = signed'(d[23:12]);
        ex = signed'(d[35:24]);
        ey = signed'(d[47:36]);
        a = '0;
        if (op == OP_READ) begin
            if (!on_grid(ex, ey))
                a.status = ST_END_OFF;
            else
                a.value = clip16(int'(prior_d) + int'(cells[flat(ex, ey)]));
        end else if (!on_grid(sx, sy)) begin
            a.status = ST_START_OFF;
        end else if (!on_grid(ex, ey)) begin
            a.status = ST_END_OFF;
        end else begin
            dx = ex - sx;
            dy = ey - sy;
            xs = (dx > 0) ? 1 : -1;
            ys = (dy > 0) ? 1 : -1;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            // octant swap: walk along the longer axis
            if (ax > ay) begin
                major = ax; minor = ay;
                mxx = xs; mxy = 0; myx = 0; myy = ys;
            end else begin
                major = ay; minor = ax;
                mxx = 0; mxy = ys; myx = xs; myy = 0;
            end
            err = 2 * minor - major;
            stp = 0;
            for (i = 0; i <= major; i++) begin
                cx = sx + i * mxx + stp * myx;
                cy = sy + i * mxy + stp * myy;
                if (on_grid(cx, cy)) begin
                    k = flat(cx, cy);
                    cells[k] = clip16(int'(cells[k]) + int'((i == major) ? occ_d : free_d));
                end
                if (err >= 0) begin
                    stp++;
                    err -= 2 * major;
                end
                err += 2 * minor;
            end
            a.touched = 9'(major + 1);
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 65536; n++)
                cells[n] = '0;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            free_d     = -16'sd102;
            occ_d      = 16'sd217;
            prior_d    = '0;
            answers_due.delete();
            o_pending  <= 0;
            o_failures <= 0;
        end else begin
            pushed = 0;
            popped = 0;
            bad    = 0;
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_GRID_WIDTH:  width_reg  = pwdata[8:0];
                    REG_GRID_HEIGHT: height_reg = pwdata[8:0];
                    REG_FREE_DELTA:  free_d     = pwdata[15:0];
                    REG_OCC_DELTA:   occ_d      = pwdata[15:0];
                    REG_PRIOR:       prior_d    = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                answers_due.push_back(apply_to_grid(s_axis_tuser, s_axis_tdata));
                pushed = 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_answer'(m_axis_tdata);
                if (answers_due.size() == 0) begin
                    $display("%0t: result word %h with none expected", $time, m_axis_tdata);
                    bad = 1;
                end else begin
                    want   = answers_due.pop_front();
                    popped = 1;
                    if (got.status !== want.status || got.value !== want.value ||
                        got.touched !== want.touched || got.pad !== want.pad) begin
                        $display("%0t: expected status %0d value %0d touched %0d pad %h,",
                                 $time, want.status, $signed(want.value), want.touched,
                                 want.pad);
                        $display("%0t:   actual status %0d value %0d touched %0d pad %h",
                                 $time, got.status, $signed(got.value), got.touched, got.pad);
                        bad = 1;
                    end
                end
            end
            o_pending  <= o_pending + pushed - popped;
            o_failures <= o_failures + bad;
        end
    end

endmodule

FILE: dv/tb_top.sv
// Top of the occupancy_grid_ray_update testbench: clock, reset, register phases,
// directed and random words with bursty sender and stalling receiver, verdict.
// Depends on ogru_pkg, the block's RTL and grid_ray_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ogru_pkg::*;

    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 200;
    localparam int CYCLE_LIMIT     = 3_000_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int failures;
    int cycles      = 0;
    int burst_left  = 0;
    bit tx_up       = 1'b0;
    int span_w      = 256;
    int span_h      = 256;

    logic [1:0] rx_mode = 2'd0;
    logic [7:0] rx_tick = '0;

    occupancy_grid_ray_update uut (.*);

    grid_ray_checker u_check (
        .*,
        .o_pending  (pending),
        .o_failures (failures)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Receiver stall pattern, picked anew each time the 8-bit tick counter wraps.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick == 8'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= (rx_tick[1:0] == 2'd3);
            2'd2:    m_axis_tready <= ($urandom_range(0, 9) < 7);
            default: m_axis_tready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper bits of each write are junk; the block keeps only the register's width.
    task automatic set_grid(input int w, input int h, input int fd, input int od, input int pr);
        logic [31:0] junk;
        junk = $urandom;
        apb_write(REG_GRID_WIDTH,  {junk[31:9], 9'(w)});
        apb_write(REG_GRID_HEIGHT, {junk[22:0], 9'(h)});
        apb_write(REG_FREE_DELTA,  {junk[15:0], 16'(fd)});
        apb_write(REG_OCC_DELTA,   {junk[31:16], 16'(od)});
        apb_write(REG_PRIOR,       {junk[23:8], 16'(pr)});
        span_w = (9'(w) > 9'd256) ? 256 : int'(9'(w));
        span_h = (9'(h) > 9'd256) ? 256 : int'(9'(h));
    endtask

    task automatic push_word(input logic op, input int sx, input int sy, input int ex,
                             input int ey);
        int gap;
        if (burst_left == 0)
            burst_left = $urandom_range(1, 20);
        s_axis_tvalid <= 1'b1;
        tx_up = 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {12'(ey), 12'(ex), 12'(sy), 12'(sx)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                tx_up = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Mostly on the map, some at its edges, some anywhere in the field's range.
    function automatic int pick_coord(int lim);
        int roll;
        roll = $urandom_range(0, 99);
        if (lim == 0 || roll < 8)
            return $urandom_range(0, 4095) - 2048;
        if (roll < 14) begin
            case ($urandom_range(0, 3))
                0:       return -1;
                1:       return lim;
                2:       return lim - 1;
                default: return 0;
            endcase
        end
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 40);
        return $urandom_range(0, 511);
    endfunction

    function automatic int pick_delta();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 600) - 300;
        return $urandom_range(0, 65535) - 32768;
    endfunction

    task automatic push_random();
        logic op;
        op = ($urandom_range(0, 99) < 30) ? OP_READ : OP_RAY;
        push_word(op, pick_coord(span_w), pick_coord(span_h), pick_coord(span_w),
                  pick_coord(span_h));
    endtask

    task automatic settle(input int tail);
        if (tx_up) begin
            s_axis_tvalid <= 1'b0;
            tx_up = 1'b0;
        end
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Reset register values: 256 x 256 map, free -102, occupied 217, prior 0.
    task automatic directed_words();
        push_word(OP_READ, 0, 0, 0, 0);
        push_word(OP_RAY, 5, 5, 5, 5);                 // zero-length ray
        push_word(OP_READ, 0, 0, 5, 5);
        push_word(OP_RAY, 0, 0, 255, 255);             // longest ray, 256 cells
        push_word(OP_READ, 0, 0, 255, 255);
        push_word(OP_READ, 0, 0, 100, 100);
        push_word(OP_RAY, 255, 0, 0, 3);
        push_word(OP_RAY, 10, 200, 12, 0);
        push_word(OP_RAY, 0, 255, 255, 0);
        push_word(OP_RAY, 0, 0, 4, 2);                 // error term ties
        push_word(OP_RAY, 7, 3, 3, 7);
        push_word(OP_RAY, -1, 0, 3, 3);
        push_word(OP_RAY, 256, 0, -2048, 2047);        // both off: start reported
        push_word(OP_RAY, 0, 0, 0, -2048);
        push_word(OP_RAY, 3, 3, 2047, 5);
        push_word(OP_RAY, 2047, -2048, 0, 0);
        push_word(OP_READ, -2048, 2047, -2048, -2048);
        push_word(OP_READ, 0, 0, 256, 0);
        push_word(OP_READ, 0, 0, 0, 256);
        push_word(OP_READ, -1, -1, 2, 1);              // start ignored on a read
        push_word(OP_READ, 2047, 2047, 0, 0);
        push_word(OP_RAY, 255, 255, 255, 255);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle(8);
                case (ph)
                    1:       set_grid(16, 16, -102, 217, 0);
                    2:       set_grid(1, 256, -32768, 32767, 32767);
                    3:       set_grid(0, 7, 5, -5, -32768);
                    4:       set_grid(511, 1, 32767, -32768, -32768);
                    5:       set_grid(256, 0, 100, 100, 100);
                    default: set_grid(pick_size(), pick_size(), pick_delta(), pick_delta(),
                                      $urandom_range(0, 65535) - 32768);
                endcase
            end else begin
                directed_words();
            end
            repeat (WORDS_PER_PHASE) push_random();
        end
        settle(300);
        if (failures == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
